/* hdl/dbe_pkg.sv */
// dbe_pkg: shared types and constants of the two-key digit editor.
// Used by every module of the editor; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dbe_pkg;

    localparam int unsigned BCD_W   = 28;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CUR_W   = 3;
    localparam int unsigned SHOWN   = 7;   // digits visible on the 28-bit bus

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 8'd3;
    localparam logic [CFG_W-1:0] HOLD_CAP_RST = 8'd70;
    localparam logic [CFG_W-1:0] IDLE_TO_RST  = 8'd250;
    localparam logic [CFG_W-1:0] COUNT_MAX    = 8'd255;
    localparam logic [3:0]       DIGIT_TOP    = 4'd9;
    localparam logic [3:0]       CURSOR_TOP   = 4'd7;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_KEY1  = 2'd1,
        MODE_KEY2  = 2'd2,
        MODE_LOAD  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CLICK_NONE = 2'd0,
        CLICK_ONE  = 2'd1,
        CLICK_TWO  = 2'd2
    } t_click;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_HOLD_CAP  = 2'd1,
        CFG_IDLE_TO   = 2'd2
    } t_cfg_idx;

    // next-state view of the key engine, captured into the result word
    typedef struct packed {
        t_click           click;
        logic [CUR_W-1:0] cursor;
        logic             editing;
        logic             running;
    } t_status;

    // update request to the digit store
    typedef struct packed {
        logic             load_en;
        logic [BCD_W-1:0] load_bcd;
        logic             inc_en;
        logic [CUR_W-1:0] inc_pos;   // 1-based cursor position
    } t_digit_cmd;

endpackage

`default_nettype wire

/* hdl/dbe_ctrl.sv */
// dbe_ctrl: configuration registers, key pending flags, shared hold counter,
// idle counter, cursor, edit flag and engine flag. Depends on dbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbe_ctrl #(
    parameter int unsigned NUM_DIGITS = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_idx,
    input  wire logic [dbe_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                     i_fire,
    input  wire dbe_pkg::t_mode           i_mode,
    input  wire logic                     i_key_one_down,
    input  wire logic                     i_key_two_down,
    input  wire logic [dbe_pkg::BCD_W-1:0] i_load_bcd,
    output dbe_pkg::t_status              o_status,
    output dbe_pkg::t_digit_cmd           o_cmd
);
    import dbe_pkg::*;

    localparam logic [3:0] NUM_DIG = 4'(NUM_DIGITS);

    logic [CFG_W-1:0] r_debounce, r_hold_cap, r_idle_to;
    logic             r_pend1, r_pend2, r_edit, r_engine;
    logic [CFG_W-1:0] r_hold, r_idle;
    logic [CUR_W-1:0] r_cursor;

    logic             n_pend1, n_pend2, n_edit, n_engine;
    logic [CFG_W-1:0] n_hold, n_idle;
    logic [CUR_W-1:0] n_cursor;
    t_click           status;
    logic [3:0]       step;
    logic             inc_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_hold_cap <= HOLD_CAP_RST;
            r_idle_to  <= IDLE_TO_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_HOLD_CAP: r_hold_cap <= i_cfg_data;
                CFG_IDLE_TO:  r_idle_to  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pend1  = r_pend1;
        n_pend2  = r_pend2;
        n_edit   = r_edit;
        n_engine = r_engine;
        n_hold   = r_hold;
        n_idle   = r_idle;
        n_cursor = r_cursor;
        status   = CLICK_NONE;
        step     = 4'({1'b0, r_cursor} + 4'd1);
        inc_en   = 1'b0;
        case (i_mode)
            MODE_KEY1: begin
                n_pend1  = 1'b1;
                n_engine = 1'b1;
            end
            MODE_KEY2: begin
                n_pend2  = 1'b1;
                n_engine = 1'b1;
            end
            MODE_LOAD: ;
            default: begin
                if (r_engine) begin
                    // key one first, key two result overrides it
                    if (r_pend1) begin
                        if (i_key_one_down) begin
                            n_idle = '0;
                            if (n_hold <= r_hold_cap && n_hold != COUNT_MAX)
                                n_hold = n_hold + 8'd1;
                        end else begin
                            status  = (n_hold > r_debounce) ? CLICK_ONE : CLICK_NONE;
                            n_hold  = '0;
                            n_pend1 = 1'b0;
                        end
                    end else begin
                        n_idle = n_idle + 8'd1;
                    end
                    if (r_pend2) begin
                        if (i_key_two_down) begin
                            n_idle = '0;
                            if (n_hold <= r_hold_cap && n_hold != COUNT_MAX)
                                n_hold = n_hold + 8'd1;
                        end else begin
                            status  = (n_hold > r_debounce) ? CLICK_TWO : CLICK_NONE;
                            n_hold  = '0;
                            n_pend2 = 1'b0;
                        end
                    end
                    if (status == CLICK_ONE) begin
                        n_edit = 1'b1;
                        if (step > NUM_DIG || step > CURSOR_TOP)
                            n_cursor = CUR_W'(1);
                        else
                            n_cursor = step[CUR_W-1:0];
                    end else if (status == CLICK_TWO) begin
                        inc_en = (r_cursor != '0) && ({1'b0, r_cursor} <= NUM_DIG);
                    end
                    if (n_idle >= r_idle_to) begin
                        n_cursor = '0;
                        n_edit   = 1'b0;
                        n_idle   = '0;
                        n_engine = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend1  <= 1'b0;
            r_pend2  <= 1'b0;
            r_edit   <= 1'b0;
            r_engine <= 1'b0;
            r_hold   <= '0;
            r_idle   <= '0;
            r_cursor <= '0;
        end else if (i_fire) begin
            r_pend1  <= n_pend1;
            r_pend2  <= n_pend2;
            r_edit   <= n_edit;
            r_engine <= n_engine;
            r_hold   <= n_hold;
            r_idle   <= n_idle;
            r_cursor <= n_cursor;
        end
    end

    always_comb begin
        o_status.click   = status;
        o_status.cursor  = n_cursor;
        o_status.editing = n_edit;
        o_status.running = n_engine;
        o_cmd.load_en    = (i_mode == MODE_LOAD);
        o_cmd.load_bcd   = i_load_bcd;
        o_cmd.inc_en     = inc_en;
        o_cmd.inc_pos    = r_cursor;
    end

endmodule

`default_nettype wire

/* hdl/dbe_digits.sv */
// dbe_digits: the decimal digit store with load and modulo-ten increment,
// and the packed BCD view of its next contents. Depends on dbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbe_digits #(
    parameter int unsigned NUM_DIGITS = 7
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_fire,
    input  wire dbe_pkg::t_digit_cmd       i_cmd,
    output logic [dbe_pkg::BCD_W-1:0]      o_bcd
);
    import dbe_pkg::*;

    localparam int unsigned IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [3:0]       r_digit [NUM_DIGITS];
    logic [3:0]       n_digit [NUM_DIGITS];
    logic [CUR_W-1:0] pos0;
    logic [IDX_W-1:0] idx;

    // cursor is 1-based; only in-range positions arrive with inc_en set
    assign pos0 = i_cmd.inc_pos - CUR_W'(1);
    assign idx  = IDX_W'(pos0);

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (i_cmd.load_en && i < SHOWN)
                n_digit[i] = i_cmd.load_bcd[4*i +: 4];
            else if (i_cmd.load_en)
                n_digit[i] = 4'd0;
            else
                n_digit[i] = r_digit[i];
        end
        if (i_cmd.inc_en)
            n_digit[idx] = (r_digit[idx] >= DIGIT_TOP) ? 4'd0 : r_digit[idx] + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++)
                r_digit[i] <= 4'd0;
        end else if (i_fire) begin
            for (int i = 0; i < NUM_DIGITS; i++)
                r_digit[i] <= n_digit[i];
        end
    end

    always_comb begin
        o_bcd = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (i < SHOWN)
                o_bcd[4*i +: 4] = n_digit[i];
        end
    end

endmodule

`default_nettype wire

/* hdl/debounced_two_key_digit_editor.sv */
// Two-key front-panel digit editor: debounces two keys on tick items and edits
// NUM_DIGITS decimal digits with a cursor. One word is accepted every clock
// cycle while o_in_stall is low; each word's result word reaches the outputs
// through the input register, then the state update into the result register.
// A stalled result holds the pipeline only when both the input and the result
// register are full. Configuration writes take effect on the next edge.
// Depends on dbe_pkg, dbe_ctrl and dbe_digits.
`timescale 1ns / 1ps
`default_nettype none

module debounced_two_key_digit_editor #(
    parameter int unsigned NUM_DIGITS = 7
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [dbe_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_mode,
    input  wire logic                      i_key_one_down,
    input  wire logic                      i_key_two_down,
    input  wire logic [dbe_pkg::BCD_W-1:0] i_load_bcd,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [1:0]                     o_click,
    output logic [dbe_pkg::CUR_W-1:0]      o_cursor,
    output logic                           o_editing,
    output logic                           o_running,
    output logic [dbe_pkg::BCD_W-1:0]      o_digits_bcd
);
    import dbe_pkg::*;

    logic             r_in_valid;
    t_mode            r_mode;
    logic             r_k1, r_k2;
    logic [BCD_W-1:0] r_load;

    logic             r_out_valid;
    t_status          r_status;
    logic [BCD_W-1:0] r_bcd;

    logic             advance, fire;
    t_status          n_status;
    t_digit_cmd       cmd;
    logic [BCD_W-1:0] n_bcd;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else if (!o_in_stall)
            r_in_valid <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_mode <= t_mode'(i_mode);
            r_k1   <= i_key_one_down;
            r_k2   <= i_key_two_down;
            r_load <= i_load_bcd;
        end
    end

    dbe_ctrl #(.NUM_DIGITS(NUM_DIGITS)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_fire         (fire),
        .i_mode         (r_mode),
        .i_key_one_down (r_k1),
        .i_key_two_down (r_k2),
        .i_load_bcd     (r_load),
        .o_status       (n_status),
        .o_cmd          (cmd)
    );

    dbe_digits #(.NUM_DIGITS(NUM_DIGITS)) u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (cmd),
        .o_bcd   (n_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (fire)
            r_out_valid <= 1'b1;
        else if (!i_out_stall)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_status;
            r_bcd    <= n_bcd;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_click      = r_status.click;
    assign o_cursor     = r_status.cursor;
    assign o_editing    = r_status.editing;
    assign o_running    = r_status.running;
    assign o_digits_bcd = r_bcd;

endmodule

`default_nettype wire

/* hdl/dbe_checker.sv */
// dbe_checker: port-level checks on the digit editor's result channel,
// bound to the top level. Depends on debounced_two_key_digit_editor.
`timescale 1ns / 1ps
`default_nettype none

module dbe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_click,
    input wire logic [2:0]  o_cursor,
    input wire logic        o_editing,
    input wire logic        o_running,
    input wire logic [27:0] o_digits_bcd
);

    // a stalled result word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_click)
        && $stable(o_cursor) && $stable(o_editing) && $stable(o_running)
        && $stable(o_digits_bcd))
        else $error("result word changed while stalled");

    a_click_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_click != 2'd3)
        else $error("click code out of range");

    // cursor is set only by a key one click and cleared with the edit flag
    a_cursor_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_editing == (o_cursor != 3'd0))
        else $error("cursor and edit flag disagree");

    a_edit_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_editing |-> o_running)
        else $error("editing while engine stopped");

endmodule

bind debounced_two_key_digit_editor dbe_checker u_dbe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_click      (o_click),
    .o_cursor     (o_cursor),
    .o_editing    (o_editing),
    .o_running    (o_running),
    .o_digits_bcd (o_digits_bcd)
);

`default_nettype wire

/* sim/tb.sv */
// tb: self-checking bench for the two-key digit editor, key edges, ticks and digit loads
// under random idle and stall, every result word checked field by field against
// an in-bench model of the keys, cursor and digits. Depends on dbe_pkg and the editor.
`timescale 1ns / 1ps

module tb;
    import dbe_pkg::*;

    localparam int PANEL_DIGITS = 7;
    localparam int MAX_GAP      = 17;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_STALL   = 80;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        t_click           click;
        logic [CUR_W-1:0] cursor;
        logic             editing;
        logic             running;
        logic [BCD_W-1:0] digits;
    } t_panel_word;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [1:0]       i_mode;
    logic             i_key_one_down;
    logic             i_key_two_down;
    logic [BCD_W-1:0] i_load_bcd;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [1:0]       o_click;
    logic [CUR_W-1:0] o_cursor;
    logic             o_editing;
    logic             o_running;
    logic [BCD_W-1:0] o_digits_bcd;

    // model state of the panel
    logic [CFG_W-1:0] debounce_lim;
    logic [CFG_W-1:0] hold_lim;
    logic [CFG_W-1:0] idle_lim;
    logic             k1_armed;
    logic             k2_armed;
    logic [CFG_W-1:0] hold_ticks;
    logic [CFG_W-1:0] idle_ticks;
    logic [CUR_W-1:0] cur_pos;
    logic [3:0]       digit_mem [0:PANEL_DIGITS-1];
    logic             edit_on;
    logic             engine_run;

    t_panel_word panel_words_due [$];
    int          mismatches;
    int          words_sent;
    int          quiet_cycles;
    int          rx_hold_req;
    bit          tx_steady;
    bit          rx_steady;

    debounced_two_key_digit_editor #(
        .NUM_DIGITS(PANEL_DIGITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_key_one_down (i_key_one_down),
        .i_key_two_down (i_key_two_down),
        .i_load_bcd     (i_load_bcd),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_click        (o_click),
        .o_cursor       (o_cursor),
        .o_editing      (o_editing),
        .o_running      (o_running),
        .o_digits_bcd   (o_digits_bcd)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void bump_hold();
        if (hold_ticks <= hold_lim && hold_ticks != COUNT_MAX) begin
            hold_ticks = hold_ticks + 8'd1;
        end
    endfunction

    function automatic t_click release_hold(t_click code);
        t_click r;
        r = (hold_ticks > debounce_lim) ? code : CLICK_NONE;
        hold_ticks = '0;
        return r;
    endfunction

    function automatic t_panel_word step_panel(t_mode m, logic k1, logic k2,
                                               logic [BCD_W-1:0] bcd);
        t_panel_word r;
        t_click      status;
        int          nxt;
        logic [4:0]  d;
        status = CLICK_NONE;
        case (m)
            MODE_KEY1: begin
                k1_armed = 1'b1;
                engine_run = 1'b1;
            end
            MODE_KEY2: begin
                k2_armed = 1'b1;
                engine_run = 1'b1;
            end
            MODE_LOAD: begin
                for (int i = 0; i < PANEL_DIGITS; i++) digit_mem[i] = bcd[4*i +: 4];
            end
            default: begin
                if (engine_run) begin
                    if (k1_armed) begin
                        if (k1) begin
                            idle_ticks = '0;
                            bump_hold();
                        end else begin
                            status = release_hold(CLICK_ONE);
                            k1_armed = 1'b0;
                        end
                    end else begin
                        idle_ticks = idle_ticks + 8'd1;
                    end
                    // key two resolves last and its outcome wins
                    if (k2_armed) begin
                        if (k2) begin
                            idle_ticks = '0;
                            bump_hold();
                        end else begin
                            status = release_hold(CLICK_TWO);
                            k2_armed = 1'b0;
                        end
                    end
                    if (status == CLICK_ONE) begin
                        edit_on = 1'b1;
                        nxt = int'(cur_pos) + 1;
                        if (nxt > PANEL_DIGITS || nxt > int'(CURSOR_TOP)) nxt = 1;
                        cur_pos = CUR_W'(nxt);
                    end else if (status == CLICK_TWO) begin
                        if (cur_pos >= 1 && int'(cur_pos) <= PANEL_DIGITS) begin
                            d = digit_mem[int'(cur_pos) - 1] + 5'd1;
                            if (d > DIGIT_TOP) d = '0;
                            digit_mem[int'(cur_pos) - 1] = d[3:0];
                        end
                    end
                    // timeout is checked last and undoes this tick's cursor change
                    if (idle_ticks >= idle_lim) begin
                        cur_pos = '0;
                        edit_on = 1'b0;
                        idle_ticks = '0;
                        engine_run = 1'b0;
                    end
                end
            end
        endcase
        r.click = status;
        r.cursor = cur_pos;
        r.editing = edit_on;
        r.running = engine_run;
        r.digits = '0;
        for (int i = 0; i < PANEL_DIGITS; i++) r.digits[4*i +: 4] = digit_mem[i];
        return r;
    endfunction

    task automatic send_word(t_mode m, logic k1, logic k2, logic [BCD_W-1:0] bcd);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_key_one_down <= k1;
        i_key_two_down <= k2;
        i_load_bcd <= bcd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        panel_words_due.push_back(step_panel(m, k1, k2, bcd));
        words_sent++;
    endtask

    task automatic send_tick(logic k1, logic k2);
        send_word(MODE_TICK, k1, k2, BCD_W'($urandom));
    endtask

    // edge(s), held ticks, then one release tick for the chosen keys
    task automatic press_key(logic one, logic two, int held);
        if (one && two && $urandom_range(0, 1)) begin
            send_word(MODE_KEY2, 1'($urandom), 1'($urandom), BCD_W'($urandom));
            send_word(MODE_KEY1, 1'($urandom), 1'($urandom), BCD_W'($urandom));
        end else begin
            if (one) send_word(MODE_KEY1, 1'($urandom), 1'($urandom), BCD_W'($urandom));
            if (two) send_word(MODE_KEY2, 1'($urandom), 1'($urandom), BCD_W'($urandom));
        end
        repeat (held) send_tick(one ? 1'b1 : 1'($urandom), two ? 1'b1 : 1'($urandom));
        send_tick(one ? 1'b0 : 1'($urandom), two ? 1'b0 : 1'($urandom));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (panel_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: debounce_lim = val;
            CFG_HOLD_CAP: hold_lim = val;
            CFG_IDLE_TO:  idle_lim = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] cap,
                                  logic [CFG_W-1:0] tmo);
        settle();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_HOLD_CAP, cap);
        write_reg(CFG_IDLE_TO, tmo);
        // unmapped index must be ignored
        write_reg(CFG_SPARE, CFG_W'($urandom));
    endtask

    task automatic check_field(string name, logic [BCD_W-1:0] want, logic [BCD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_panel_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (panel_words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, got click %0d digits %0h",
                         $time, o_click, o_digits_bcd);
                mismatches++;
            end else begin
                want = panel_words_due.pop_front();
                check_field("click", BCD_W'(want.click), BCD_W'(o_click));
                check_field("cursor", BCD_W'(want.cursor), BCD_W'(o_cursor));
                check_field("editing", BCD_W'(want.editing), BCD_W'(o_editing));
                check_field("running", BCD_W'(want.running), BCD_W'(o_running));
                check_field("digits", want.digits, o_digits_bcd);
            end
        end
    end

    // result side: random stall per word, plus an occasional long hold-off
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req != 0) begin
                n = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                n = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_stopped_and_load();
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_word(MODE_LOAD, 1'b1, 1'b1, 28'hFFFFFFF);
    endtask

    task automatic test_clicks();
        apply_settings(8'd0, 8'd254, 8'd255);
        press_key(1'b0, 1'b1, 1);   // no cursor yet, digits stay
        press_key(1'b1, 1'b0, 1);
        press_key(1'b0, 1'b1, 1);   // invalid nibble rolls to zero
        press_key(1'b1, 1'b1, 1);   // both released on one tick
        press_key(1'b1, 1'b0, 0);   // too short
        send_word(MODE_LOAD, 1'b0, 1'b0, '0);
    endtask

    task automatic test_timeout();
        apply_settings(8'd0, 8'd0, 8'd1);
        send_tick(1'b1, 1'b1);
        press_key(1'b0, 1'b1, 1);   // click and timeout on the same tick
        press_key(1'b1, 1'b0, 1);
        send_tick(1'b0, 1'b0);
        apply_settings(8'd0, 8'd0, 8'd0);
        press_key(1'b1, 1'b0, 1);   // stops while key one still armed
        send_word(MODE_KEY1, 1'b0, 1'b0, BCD_W'($urandom));
        send_tick(1'b0, 1'($urandom));
    endtask

    task automatic test_hold_saturation();
        apply_settings(8'd254, 8'd254, 8'd255);
        press_key(1'b1, 1'b0, 258);
    endtask

    task automatic test_backpressure();
        settle();
        tx_steady = 1'b1;
        rx_hold_req = LONG_STALL;
        repeat (30) begin
            send_word(t_mode'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                      BCD_W'($urandom));
        end
        tx_steady = 1'b0;
        settle();
    endtask

    task automatic run_random_traffic(int words);
        int               stop_at;
        int               pick;
        int               held;
        logic             one;
        logic             two;
        logic [BCD_W-1:0] bcd;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 11) == 0) tx_steady = !tx_steady;
            if ($urandom_range(0, 11) == 0) rx_steady = !rx_steady;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                pick = $urandom_range(0, 9);
                one = (pick < 6) || (pick == 9);
                two = (pick >= 6);
                if ($urandom_range(0, 9) == 0) begin
                    held = int'(debounce_lim) + $urandom_range(0, 2);
                end else begin
                    held = $urandom_range(0, 6);
                end
                press_key(one, two, held);
            end else if (pick < 75) begin
                bcd = BCD_W'($urandom);
                if ($urandom_range(0, 1)) begin
                    for (int i = 0; i < PANEL_DIGITS; i++)
                        bcd[4*i +: 4] = 4'($urandom_range(0, 9));
                end
                send_word(MODE_LOAD, 1'($urandom), 1'($urandom), bcd);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 24)) send_tick(1'($urandom), 1'($urandom));
            end else begin
                send_word(t_mode'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                          BCD_W'($urandom));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        apply_settings(DEBOUNCE_RST, HOLD_CAP_RST, IDLE_TO_RST);
        run_random_traffic(150);
        apply_settings(8'd0, 8'd0, 8'd1);
        run_random_traffic(100);
        apply_settings(8'd255, 8'd254, 8'd255);
        run_random_traffic(100);
        repeat (2) begin
            apply_settings(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 254)),
                           CFG_W'($urandom_range(1, 40)));
            run_random_traffic(65);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DEBOUNCE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = MODE_TICK;
        i_key_one_down = 1'b0;
        i_key_two_down = 1'b0;
        i_load_bcd = '0;
        i_out_stall = 1'b0;
        mismatches = 0;
        words_sent = 0;
        quiet_cycles = 0;
        rx_hold_req = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        debounce_lim = DEBOUNCE_RST;
        hold_lim = HOLD_CAP_RST;
        idle_lim = IDLE_TO_RST;
        k1_armed = 1'b0;
        k2_armed = 1'b0;
        hold_ticks = '0;
        idle_ticks = '0;
        cur_pos = '0;
        for (int i = 0; i < PANEL_DIGITS; i++) digit_mem[i] = '0;
        edit_on = 1'b0;
        engine_run = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_stopped_and_load();
        test_clicks();
        test_timeout();
        test_hold_saturation();
        test_backpressure();
        test_random_traffic();
        settle();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
